// ===== rtl/bph_pkg.sv =====
// ----------------------------------------------------------------------------
// bph_pkg
// Shared types and constants of the blob projection histogram: payload
// structs, op and selector codes, controller states, divider hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bph_pkg;

  // Default frame limits, handed to the top level as parameter defaults
  localparam int MaxWidthDef  = 1024;
  localparam int MaxHeightDef = 1024;

  // Depth histogram has one bin per valid depth code
  localparam int DepthBins = 255;
  localparam int DepthAw   = $clog2(DepthBins);

  // Field widths
  localparam int OpW    = 2;
  localparam int LabelW = 16;
  localparam int DepthW = 8;
  localparam int CoordW = 10;
  localparam int SelW   = 2;
  localparam int LineW  = 11;  // column / row bin counters
  localparam int CountW = 21;  // depth bins and pixel total
  localparam int FracBits = 16;
  localparam int FracW  = FracBits + 1;

  localparam logic [DepthW-1:0] NoDepth = 8'd255;
  localparam logic [FracW-1:0]  OneQ16  = 17'h10000;

  typedef enum logic [OpW-1:0] {
    OpClear = 2'd0,
    OpAccum = 2'd1,
    OpRead  = 2'd2
  } bph_op_e;

  typedef enum logic [SelW-1:0] {
    SelColumn = 2'd0,
    SelRow    = 2'd1,
    SelDepth  = 2'd2
  } bph_sel_e;

  typedef enum logic [2:0] {
    StSweep,
    StIdle,
    StAccWb,
    StRdData,
    StDivWait
  } bph_state_e;

  typedef struct packed {
    logic [OpW-1:0]    op;
    logic [LabelW-1:0] pixel_label;
    logic [DepthW-1:0] depth;
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
    logic [SelW-1:0]   hist_select;
    logic [CoordW-1:0] bin_index;
  } bph_in_t;

  typedef struct packed {
    logic [CountW-1:0] bin_count;
    logic [CountW-1:0] pixel_total;
    logic [FracW-1:0]  bin_fraction;
    logic [DepthW-1:0] depth_low;
    logic [DepthW-1:0] depth_high;
    logic              region_empty;
  } bph_out_t;

  // Controller to divider
  typedef struct packed {
    logic              start;
    logic [CountW-1:0] numer;
    logic [CountW-1:0] denom;
  } bph_div_req_t;

  // Divider to controller
  typedef struct packed {
    logic             done;
    logic [FracW-1:0] quot;
  } bph_div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/bph_stream_if.sv =====
// ----------------------------------------------------------------------------
// bph_stream_if
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bph_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

// ===== rtl/bph_divider.sv =====
// ----------------------------------------------------------------------------
// bph_divider
// Restoring divider for the Q1.16 bin fraction: numer * 2^16 / denom,
// one quotient bit per cycle, capped at one, zero for a zero divisor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bph_divider (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bph_pkg::bph_div_req_t req_i,
  output bph_pkg::bph_div_rsp_t rsp_o
);
  import bph_pkg::*;

  localparam int StepW = $clog2(FracBits);

  logic              busy_q, done_q;
  logic [StepW-1:0]  step_q;
  logic [CountW:0]   rem_q;
  logic [CountW-1:0] denom_q;
  logic [FracW-1:0]  quot_q;

  logic              zero_div, full_div;
  logic [CountW:0]   rem_sh, rem_nx;
  logic              bit_ge;

  // Early outs decided at start
  assign zero_div = (req_i.denom == '0);
  assign full_div = (req_i.numer >= req_i.denom);

  // One restoring step; remainder stays below twice the divisor
  always_comb begin
    rem_sh = {rem_q[CountW-1:0], 1'b0};
    bit_ge = (rem_sh >= {1'b0, denom_q});
    rem_nx = bit_ge ? (rem_sh - {1'b0, denom_q}) : rem_sh;
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (req_i.start) begin
      busy_q <= !(zero_div || full_div);
      done_q <= zero_div || full_div;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + StepW'(1);
      if (step_q == StepW'(FracBits - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      denom_q <= req_i.denom;
      rem_q   <= {1'b0, req_i.numer};
      if (zero_div) begin
        quot_q <= '0;
      end else if (full_div) begin
        quot_q <= OneQ16;
      end else begin
        quot_q <= '0;
      end
    end else if (busy_q) begin
      rem_q  <= rem_nx;
      quot_q <= {quot_q[FracW-2:0], bit_ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

`default_nettype wire

// ===== rtl/blob_projection_histogram_top.sv =====
// ----------------------------------------------------------------------------
// blob_projection_histogram_top
// Column, row and depth projection histograms of one labelled region, with
// pixel total, depth extremes and bin readout as a Q1.16 fraction.
// ----------------------------------------------------------------------------
// Timing: each histogram sits in a single-port synchronous RAM, so an
// accepted pixel is read and then written back with saturation, while a
// pixel that is rejected or an unknown op is done with in idle. A read op
// reads the RAMs, hands the bin count and total to the bit-serial
// divider and waits for its quotient, then waits only if the previous
// result is still held in the output register. Clear, and also leaving
// reset, runs a zeroing sweep over all RAMs, addresses 0 up to
// max(MAX_WIDTH, MAX_HEIGHT, 255) - 1, during which no item is taken;
// the target label register can be written at any time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module blob_projection_histogram_top #(
  parameter int MAX_WIDTH  = bph_pkg::MaxWidthDef,
  parameter int MAX_HEIGHT = bph_pkg::MaxHeightDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  bph_stream_if.sink   cfg_i,
  bph_stream_if.sink   in_i,
  bph_stream_if.source out_o
);
  import bph_pkg::*;

  localparam int ColAw    = $clog2(MAX_WIDTH);
  localparam int RowAw    = $clog2(MAX_HEIGHT);
  localparam int LineMax  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int SweepLen = (LineMax > DepthBins) ? LineMax : DepthBins;
  localparam int SweepW   = $clog2(SweepLen);

  // Histogram RAMs
  logic [LineW-1:0]  col_mem [MAX_WIDTH];
  logic [LineW-1:0]  row_mem [MAX_HEIGHT];
  logic [CountW-1:0] dep_mem [DepthBins];

  bph_state_e        state_q, state_d;
  logic [SweepW-1:0] sweep_q, sweep_d;
  logic [LabelW-1:0] target_label_q;
  logic [CountW-1:0] total_q, total_d;
  logic [DepthW-1:0] least_q, least_d;
  logic [DepthW-1:0] greatest_q, greatest_d;
  logic              out_valid_q, out_valid_d;
  bph_out_t          out_pl_q;

  // Item registers
  logic [SelW-1:0]    sel_q;
  logic [CoordW-1:0]  bin_q;
  logic [ColAw-1:0]   col_addr_q;
  logic [RowAw-1:0]   row_addr_q;
  logic [DepthW-1:0]  z_q;

  // RAM read data
  logic [LineW-1:0]  col_rd_q, row_rd_q;
  logic [CountW-1:0] dep_rd_q;

  // RAM ports
  logic              rd_en;
  logic              col_we, row_we, dep_we;
  logic [ColAw-1:0]  col_raddr, col_waddr;
  logic [RowAw-1:0]  row_raddr, row_waddr;
  logic [DepthAw-1:0] dep_raddr, dep_waddr;
  logic [LineW-1:0]  col_wdata, row_wdata;
  logic [CountW-1:0] dep_wdata;

  logic              in_fire, pix_ok, is_read, load_out;
  logic [31:0]       col_sel_ext, row_sel_ext, sweep_ext;
  logic [LineW-1:0]  col_inc, row_inc;
  logic [CountW-1:0] dep_inc, total_inc, sel_cnt;

  bph_div_req_t      div_req;
  bph_div_rsp_t      div_rsp;

  // Configuration register, always writable
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_label_q <= '0;
    end else if (cfg_i.valid) begin
      target_label_q <= cfg_i.payload;
    end
  end

  // Input decode
  assign in_fire = in_i.valid && in_i.ready;
  assign is_read = (in_i.payload.op == OpRead);
  assign pix_ok  = (in_i.payload.pixel_label == target_label_q) &&
                   (in_i.payload.depth != NoDepth) &&
                   (32'(in_i.payload.col) < 32'(MAX_WIDTH)) &&
                   (32'(in_i.payload.row) < 32'(MAX_HEIGHT)) &&
                   (32'(in_i.payload.depth) < 32'(DepthBins));

  assign col_sel_ext = is_read ? 32'(in_i.payload.bin_index) : 32'(in_i.payload.col);
  assign row_sel_ext = is_read ? 32'(in_i.payload.bin_index) : 32'(in_i.payload.row);
  assign col_raddr   = col_sel_ext[ColAw-1:0];
  assign row_raddr   = row_sel_ext[RowAw-1:0];
  assign dep_raddr   = is_read ? in_i.payload.bin_index[DepthAw-1:0]
                               : in_i.payload.depth[DepthAw-1:0];
  assign sweep_ext   = 32'(sweep_q);

  // Saturating increments of the fetched bins
  assign col_inc   = (col_rd_q == '1) ? col_rd_q : col_rd_q + LineW'(1);
  assign row_inc   = (row_rd_q == '1) ? row_rd_q : row_rd_q + LineW'(1);
  assign dep_inc   = (dep_rd_q == '1) ? dep_rd_q : dep_rd_q + CountW'(1);
  assign total_inc = (total_q == '1) ? total_q : total_q + CountW'(1);

  // Write port muxing: zeroing sweep or write-back
  always_comb begin
    if (state_q == StSweep) begin
      col_waddr = sweep_ext[ColAw-1:0];
      row_waddr = sweep_ext[RowAw-1:0];
      dep_waddr = sweep_ext[DepthAw-1:0];
      col_wdata = '0;
      row_wdata = '0;
      dep_wdata = '0;
    end else begin
      col_waddr = col_addr_q;
      row_waddr = row_addr_q;
      dep_waddr = z_q[DepthAw-1:0];
      col_wdata = col_inc;
      row_wdata = row_inc;
      dep_wdata = dep_inc;
    end
  end

  // Selected bin count for a read; out-of-range bins read as zero
  always_comb begin
    sel_cnt = '0;
    unique case (sel_q)
      SelColumn: if (32'(bin_q) < 32'(MAX_WIDTH)) sel_cnt = CountW'(col_rd_q);
      SelRow:    if (32'(bin_q) < 32'(MAX_HEIGHT)) sel_cnt = CountW'(row_rd_q);
      SelDepth:  if (32'(bin_q) < 32'(DepthBins)) sel_cnt = dep_rd_q;
      default:   sel_cnt = '0;
    endcase
  end

  // Controller: next state and outputs
  always_comb begin
    state_d     = state_q;
    sweep_d     = sweep_q;
    total_d     = total_q;
    least_d     = least_q;
    greatest_d  = greatest_q;
    in_i.ready  = 1'b0;
    rd_en       = 1'b0;
    col_we      = 1'b0;
    row_we      = 1'b0;
    dep_we      = 1'b0;
    load_out    = 1'b0;
    div_req     = '{start: 1'b0, numer: sel_cnt, denom: total_q};
    out_valid_d = out_valid_q && !out_o.ready;

    unique case (state_q)
      StSweep: begin
        col_we = (sweep_ext < 32'(MAX_WIDTH));
        row_we = (sweep_ext < 32'(MAX_HEIGHT));
        dep_we = (sweep_ext < 32'(DepthBins));
        if (sweep_q == SweepW'(SweepLen - 1)) begin
          state_d = StIdle;
        end else begin
          sweep_d = sweep_q + SweepW'(1);
        end
      end
      StIdle: begin
        in_i.ready = 1'b1;
        if (in_fire) begin
          rd_en = 1'b1;
          unique case (in_i.payload.op)
            OpClear: begin
              total_d    = '0;
              least_d    = NoDepth;
              greatest_d = '0;
              sweep_d    = '0;
              state_d    = StSweep;
            end
            OpAccum: if (pix_ok) state_d = StAccWb;
            OpRead:  state_d = StRdData;
            default: state_d = StIdle;
          endcase
        end
      end
      StAccWb: begin
        col_we  = 1'b1;
        row_we  = 1'b1;
        dep_we  = 1'b1;
        total_d = total_inc;
        if (z_q < least_q) least_d = z_q;
        if (z_q > greatest_q) greatest_d = z_q;
        state_d = StIdle;
      end
      StRdData: begin
        div_req.start = 1'b1;
        state_d       = StDivWait;
      end
      StDivWait: begin
        if (div_rsp.done && (!out_valid_q || out_o.ready)) begin
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StSweep;
      sweep_q     <= '0;
      total_q     <= '0;
      least_q     <= NoDepth;
      greatest_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      total_q     <= total_d;
      least_q     <= least_d;
      greatest_q  <= greatest_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Item capture
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sel_q      <= in_i.payload.hist_select;
      bin_q      <= in_i.payload.bin_index;
      col_addr_q <= col_raddr;
      row_addr_q <= row_raddr;
      z_q        <= in_i.payload.depth;
    end
  end

  // Histogram RAMs: one read or one write per cycle each
  always_ff @(posedge clk_i) begin
    if (col_we) col_mem[col_waddr] <= col_wdata;
    if (row_we) row_mem[row_waddr] <= row_wdata;
    if (dep_we) dep_mem[dep_waddr] <= dep_wdata;
    if (rd_en) begin
      col_rd_q <= col_mem[col_raddr];
      row_rd_q <= row_mem[row_raddr];
      dep_rd_q <= dep_mem[dep_raddr];
    end
  end

  // Fraction divider
  bph_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Output register
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_pl_q.bin_count    <= sel_cnt;
      out_pl_q.pixel_total  <= total_q;
      out_pl_q.bin_fraction <= div_rsp.quot;
      out_pl_q.depth_low    <= least_q;
      out_pl_q.depth_high   <= greatest_q;
      out_pl_q.region_empty <= (total_q == '0);
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_pl_q;

endmodule

`default_nettype wire

// ===== rtl/bph_checker.sv =====
// ----------------------------------------------------------------------------
// bph_checker
// Port-level checks on the result channel of the projection histogram,
// bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bph_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input bph_pkg::bph_out_t out_payload_i
);
  import bph_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_payload_i))
    else $error("result changed while stalled");

  // Empty flag agrees with the total
  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_payload_i.region_empty == (out_payload_i.pixel_total == '0))
    else $error("region_empty disagrees with pixel_total");

  // Empty region reports neutral values
  a_empty_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_payload_i.region_empty |->
      out_payload_i.bin_fraction == '0 && out_payload_i.bin_count == '0 &&
      out_payload_i.depth_low == NoDepth && out_payload_i.depth_high == '0)
    else $error("empty region with non-neutral fields");

  // A bin never exceeds the total; a full bin reads as one
  a_fraction: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_payload_i.bin_count <= out_payload_i.pixel_total &&
      out_payload_i.bin_fraction <= OneQ16 &&
      (out_payload_i.bin_count != out_payload_i.pixel_total ||
       out_payload_i.region_empty || out_payload_i.bin_fraction == OneQ16))
    else $error("bin fraction inconsistent with counts");

  // Depth extremes are ordered once a pixel is in
  a_depth_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_payload_i.region_empty |->
      out_payload_i.depth_low <= out_payload_i.depth_high)
    else $error("depth_low above depth_high");

endmodule

bind blob_projection_histogram_top bph_checker u_bph_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_payload_i (out_o.payload)
);

`default_nettype wire
